// ===== design/deadline_task_table_assert.svh =====
// Assertion macros used by the deadline task table executor.
`ifndef DEADLINE_TASK_TABLE_ASSERT_SVH
`define DEADLINE_TASK_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dtt_pkg.sv =====
// Types and constants for the deadline task table.
`timescale 1ns / 1ps
package dtt_pkg;

  // Input word opcodes
  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Executor sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MERGE_RD,
    S_MERGE_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FINISH
  } bk_state_t;

  // One stored task
  typedef struct packed {
    logic [31:0] owner;
    logic [31:0] deadline;
    logic [31:0] tag;
    logic        real_clk;
  } task_t;

  // Classified command passed from front to back
  typedef struct packed {
    op_t         op;
    task_t       tsk;
    logic [31:0] real_now;
    logic [31:0] play_now;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam logic [4:0]  RESULT_LIMIT = 5'd16;
  localparam logic [4:0]  COUNT_SAT    = 5'd31;
  localparam logic [31:0] DEADLINE_MAX = 32'hFFFF_FFFF;

endpackage

// ===== design/dtt_front.sv =====
// Front end: decodes an input word and works out the saturated deadline.
`timescale 1ns / 1ps
module dtt_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [31:0]       in_owner_id,
  input  logic              in_use_real_clock,
  input  logic [31:0]       in_delay_ms,
  input  logic [31:0]       in_task_tag,
  input  logic [31:0]       in_real_now_ms,
  input  logic [31:0]       in_playback_now_ms,
  input  logic              q_full,
  output logic              q_push,
  output dtt_pkg::cmd_t     q_cmd
);
  import dtt_pkg::*;

  logic [31:0] base;
  logic [32:0] sum;

  // Deadline = chosen clock + delay, clamped on overflow
  assign base = in_use_real_clock ? in_real_now_ms : in_playback_now_ms;
  assign sum  = {1'b0, base} + {1'b0, in_delay_ms};

  always_comb begin
    q_cmd.op           = op_t'(in_opcode);
    q_cmd.tsk.owner    = in_owner_id;
    q_cmd.tsk.deadline = sum[32] ? DEADLINE_MAX : sum[31:0];
    q_cmd.tsk.tag      = in_task_tag;
    q_cmd.tsk.real_clk = in_use_real_clock;
    q_cmd.real_now     = in_real_now_ms;
    q_cmd.play_now     = in_playback_now_ms;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// ===== design/dtt_cmd_queue.sv =====
// Short command queue between the front end and the executor.
`timescale 1ns / 1ps
module dtt_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtt_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          valid,
  output dtt_pkg::cmd_t head,
  input  logic          pop
);
  import dtt_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == NW'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

// ===== design/dtt_back.sv =====
// Executor: pending list, active table, merge and compacting scan, result register.
`timescale 1ns / 1ps
`include "deadline_task_table_assert.svh"
module dtt_back #(
  parameter int unsigned TASK_SLOTS    = 16,
  parameter int unsigned PENDING_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dtt_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          out_fired_valid,
  output logic [31:0]   out_fired_owner,
  output logic [31:0]   out_fired_tag,
  output logic [4:0]    out_active_count,
  output logic          out_status,
  output logic          out_last
);
  import dtt_pkg::*;

  localparam int unsigned AW  = $clog2(TASK_SLOTS);
  localparam int unsigned CW  = $clog2(TASK_SLOTS + 1);
  localparam int unsigned PAW = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int unsigned PCW = $clog2(PENDING_SLOTS + 1);
  localparam int unsigned SW  = ((CW > PCW) ? CW : PCW) + 1;
  localparam int unsigned XW  = (CW > 5) ? CW : 5;

  // Task stores
  task_t act_mem  [TASK_SLOTS];
  task_t pend_mem [PENDING_SLOTS];
  task_t act_q, pend_q;

  logic           act_we, act_re, pend_we, pend_re;
  logic [AW-1:0]  act_waddr, act_raddr;
  logic [PAW-1:0] pend_waddr, pend_raddr;
  task_t          act_wdata;

  // Control state
  bk_state_t      st_r, st_nxt;
  cmd_t           cmd_r, cmd_nxt;
  logic [CW-1:0]  au_r, au_nxt;
  logic [PCW-1:0] pu_r, pu_nxt;
  logic [PCW-1:0] pi_r, pi_nxt;
  logic [CW-1:0]  i_r, i_nxt;
  logic [CW-1:0]  wr_r, wr_nxt;
  logic [4:0]     fired_r, fired_nxt;
  logic [4:0]     cnt_r, cnt_nxt;
  logic           status_r, status_nxt;
  logic           held_v_r, held_v_nxt;
  task_t          held_r, held_nxt;

  // Result register
  logic           out_v_r, out_v_nxt;
  logic           o_fv_r, o_fv_nxt;
  logic [31:0]    o_owner_r, o_owner_nxt;
  logic [31:0]    o_tag_r, o_tag_nxt;
  logic [4:0]     o_cnt_r, o_cnt_nxt;
  logic           o_status_r, o_status_nxt;
  logic           o_last_r, o_last_nxt;

  logic           out_free, drop, hit, advance;
  logic [SW-1:0]  total;
  logic [XW-1:0]  au_x;
  logic [31:0]    now_ms;
  logic [PCW-1:0] pi_inc;
  logic [CW-1:0]  i_inc;

  assign out_free = !out_v_r || out_ready;
  assign total    = SW'(au_r) + SW'(pu_r);
  assign drop     = (pu_r >= PCW'(PENDING_SLOTS)) || (total >= SW'(TASK_SLOTS));
  assign au_x     = XW'(au_r);
  assign now_ms   = act_q.real_clk ? cmd_r.real_now : cmd_r.play_now;
  assign pi_inc   = pi_r + PCW'(1);
  assign i_inc    = i_r + CW'(1);

  // Due test on a tick, owner match on a remove
  assign hit = (cmd_r.op == OP_TICK) ?
               ((fired_r < RESULT_LIMIT) && (now_ms > act_q.deadline)) :
               (act_q.owner == cmd_r.tsk.owner);

  // Sequencer: next state, store controls and result loading
  always_comb begin
    st_nxt       = st_r;
    cmd_nxt      = cmd_r;
    au_nxt       = au_r;
    pu_nxt       = pu_r;
    pi_nxt       = pi_r;
    i_nxt        = i_r;
    wr_nxt       = wr_r;
    fired_nxt    = fired_r;
    cnt_nxt      = cnt_r;
    status_nxt   = status_r;
    held_v_nxt   = held_v_r;
    held_nxt     = held_r;
    out_v_nxt    = out_v_r && !out_ready;
    o_fv_nxt     = o_fv_r;
    o_owner_nxt  = o_owner_r;
    o_tag_nxt    = o_tag_r;
    o_cnt_nxt    = o_cnt_r;
    o_status_nxt = o_status_r;
    o_last_nxt   = o_last_r;
    q_pop        = 1'b0;
    act_we       = 1'b0;
    act_re       = 1'b0;
    act_waddr    = au_r[AW-1:0];
    act_raddr    = i_r[AW-1:0];
    act_wdata    = pend_q;
    pend_we      = 1'b0;
    pend_re      = 1'b0;
    pend_waddr   = pu_r[PAW-1:0];
    pend_raddr   = pi_r[PAW-1:0];
    advance      = 1'b1;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          cmd_nxt    = q_cmd;
          i_nxt      = '0;
          wr_nxt     = '0;
          pi_nxt     = '0;
          fired_nxt  = '0;
          cnt_nxt    = '0;
          status_nxt = 1'b0;
          held_v_nxt = 1'b0;
          case (q_cmd.op)
            OP_SCHED: begin
              if (drop) begin
                status_nxt = 1'b1;
              end else begin
                pend_we = 1'b1;
                pu_nxt  = pu_r + PCW'(1);
              end
              st_nxt = S_FINISH;
            end
            OP_TICK: begin
              cnt_nxt = (au_x > XW'(COUNT_SAT)) ? COUNT_SAT : au_x[4:0];
              if (pu_r != '0) begin
                st_nxt = S_MERGE_RD;
              end else if (au_r != '0) begin
                st_nxt = S_SCAN_RD;
              end else begin
                st_nxt = S_FINISH;
              end
            end
            OP_REMOVE: begin
              st_nxt = (au_r != '0) ? S_SCAN_RD : S_FINISH;
            end
            default: begin
              st_nxt = S_FINISH;
            end
          endcase
        end
      end

      // Pending list appended to the table in order
      S_MERGE_RD: begin
        pend_re = 1'b1;
        st_nxt  = S_MERGE_WR;
      end

      S_MERGE_WR: begin
        act_we = 1'b1;
        au_nxt = au_r + CW'(1);
        pi_nxt = pi_inc;
        if (pi_inc == pu_r) begin
          pu_nxt = '0;
          st_nxt = S_SCAN_RD;
        end else begin
          st_nxt = S_MERGE_RD;
        end
      end

      S_SCAN_RD: begin
        act_re = 1'b1;
        st_nxt = S_SCAN_EV;
      end

      // Fire or drop on a hit, otherwise compact the entry down
      S_SCAN_EV: begin
        if (hit) begin
          if (cmd_r.op == OP_TICK) begin
            if (held_v_r) begin
              if (out_free) begin
                out_v_nxt    = 1'b1;
                o_fv_nxt     = 1'b1;
                o_owner_nxt  = held_r.owner;
                o_tag_nxt    = held_r.tag;
                o_cnt_nxt    = cnt_r;
                o_status_nxt = 1'b0;
                o_last_nxt   = 1'b0;
              end else begin
                advance = 1'b0;
              end
            end
            if (advance) begin
              held_v_nxt = 1'b1;
              held_nxt   = act_q;
              fired_nxt  = fired_r + 5'd1;
            end
          end
        end else begin
          act_we    = 1'b1;
          act_waddr = wr_r[AW-1:0];
          act_wdata = act_q;
          wr_nxt    = wr_r + CW'(1);
        end
        if (advance) begin
          i_nxt  = i_inc;
          st_nxt = (i_inc == au_r) ? S_FINISH : S_SCAN_RD;
        end
      end

      // Closing word of the item
      S_FINISH: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          o_fv_nxt     = held_v_r;
          o_owner_nxt  = held_v_r ? held_r.owner : '0;
          o_tag_nxt    = held_v_r ? held_r.tag : '0;
          o_cnt_nxt    = cnt_r;
          o_status_nxt = status_r;
          o_last_nxt   = 1'b1;
          if (cmd_r.op == OP_TICK || cmd_r.op == OP_REMOVE) begin
            au_nxt = wr_r;
          end
          st_nxt = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      au_r     <= '0;
      pu_r     <= '0;
      pi_r     <= '0;
      i_r      <= '0;
      wr_r     <= '0;
      fired_r  <= '0;
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      au_r     <= au_nxt;
      pu_r     <= pu_nxt;
      pi_r     <= pi_nxt;
      i_r      <= i_nxt;
      wr_r     <= wr_nxt;
      fired_r  <= fired_nxt;
      held_v_r <= held_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    cnt_r      <= cnt_nxt;
    status_r   <= status_nxt;
    held_r     <= held_nxt;
    o_fv_r     <= o_fv_nxt;
    o_owner_r  <= o_owner_nxt;
    o_tag_r    <= o_tag_nxt;
    o_cnt_r    <= o_cnt_nxt;
    o_status_r <= o_status_nxt;
    o_last_r   <= o_last_nxt;
  end

  // Active table memory, registered read
  always_ff @(posedge clk) begin
    if (act_we) begin
      act_mem[act_waddr] <= act_wdata;
    end
    if (act_re) begin
      act_q <= act_mem[act_raddr];
    end
  end

  // Pending list memory, registered read
  always_ff @(posedge clk) begin
    if (pend_we) begin
      pend_mem[pend_waddr] <= q_cmd.tsk;
    end
    if (pend_re) begin
      pend_q <= pend_mem[pend_raddr];
    end
  end

  assign out_valid        = out_v_r;
  assign out_fired_valid  = o_fv_r;
  assign out_fired_owner  = o_owner_r;
  assign out_fired_tag    = o_tag_r;
  assign out_active_count = o_cnt_r;
  assign out_status       = o_status_r;
  assign out_last         = o_last_r;

  // Checks
  `DTT_ASSERT_NOW(a_active_bound, 1'b1, au_r <= CW'(TASK_SLOTS), "active count overflow")
  `DTT_ASSERT_NOW(a_merge_fits, st_r == S_MERGE_WR, au_r < CW'(TASK_SLOTS), "merge overflow")
  `DTT_ASSERT_NOW(a_compact_order, st_r == S_SCAN_EV, wr_r <= i_r, "compaction overtook scan")
  `DTT_ASSERT_NOW(a_fire_limit, 1'b1, fired_r <= RESULT_LIMIT, "too many fired words")
  `DTT_ASSERT_NEXT(a_finish_done, st_r == S_FINISH && out_free, st_r == S_IDLE, "finish stuck")

endmodule

// ===== design/deadline_task_table.sv =====
// Top level of the deadline task table.
`timescale 1ns / 1ps
// Deadline task table. Input words schedule a task (owner, tag, deadline = chosen clock + delay,
// clamped at the maximum), tick the table, or remove the active tasks of one owner. A schedule
// lands in a pending list and is dropped with status 1 when that list or the whole table is
// full. A tick reports the active count taken before the merge, appends the pending tasks and
// fires, in table order, every task whose clock is strictly past its deadline (at most 16 per
// tick); the final word of each item carries last. The front end decodes words into a
// two-entry command queue, so it keeps taking words while the executor works. In the executor each
// pending task of a tick is read and written in the merge, then scanned with the rest; the
// pending and active memories have registered reads, and the executor waits while a result
// word is not taken. An accepted word is registered in the queue before the executor picks it
// up. Results are held in an output register.
module deadline_task_table #(
  parameter int unsigned TASK_SLOTS    = 16,
  parameter int unsigned PENDING_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_owner_id,
  input  logic        in_use_real_clock,
  input  logic [31:0] in_delay_ms,
  input  logic [31:0] in_task_tag,
  input  logic [31:0] in_real_now_ms,
  input  logic [31:0] in_playback_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_fired_valid,
  output logic [31:0] out_fired_owner,
  output logic [31:0] out_fired_tag,
  output logic [4:0]  out_active_count,
  output logic        out_status,
  output logic        out_last
);
  import dtt_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  dtt_front u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_owner_id        (in_owner_id),
    .in_use_real_clock  (in_use_real_clock),
    .in_delay_ms        (in_delay_ms),
    .in_task_tag        (in_task_tag),
    .in_real_now_ms     (in_real_now_ms),
    .in_playback_now_ms (in_playback_now_ms),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_cmd              (push_cmd)
  );

  dtt_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd),
    .pop      (q_pop)
  );

  dtt_back #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PENDING_SLOTS (PENDING_SLOTS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (head_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fired_valid  (out_fired_valid),
    .out_fired_owner  (out_fired_owner),
    .out_fired_tag    (out_fired_tag),
    .out_active_count (out_active_count),
    .out_status       (out_status),
    .out_last         (out_last)
  );

endmodule

// ===== tb/deadline_task_table_tb.sv =====
// Self-checking testbench for the deadline task table: directed words, then random traffic.
`timescale 1ns / 1ps
module deadline_task_table_tb;
  import dtt_pkg::*;

  localparam int unsigned TASK_SLOTS    = 16;
  localparam int unsigned PENDING_SLOTS = 8;
  localparam int unsigned RANDOM_WORDS  = 450;
  localparam int unsigned CALM_FROM     = 100;
  localparam int unsigned CALM_TO       = 180;
  localparam int unsigned STALL_AT      = 220;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned DRAIN_CYCLES  = 64;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // One input word as offered to the block
  typedef struct {
    op_t         op;
    logic [31:0] owner;
    logic        real_sel;
    logic [31:0] delay;
    logic [31:0] tag;
    logic [31:0] real_now;
    logic [31:0] play_now;
  } word_t;

  // One result word as seen on the output
  typedef struct packed {
    logic        valid;
    logic [31:0] owner;
    logic [31:0] tag;
    logic [4:0]  count;
    logic        status;
    logic        last;
  } fire_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_owner_id = '0;
  logic        in_use_real_clock = 1'b0;
  logic [31:0] in_delay_ms = '0;
  logic [31:0] in_task_tag = '0;
  logic [31:0] in_real_now_ms = '0;
  logic [31:0] in_playback_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_fired_valid;
  logic [31:0] out_fired_owner;
  logic [31:0] out_fired_tag;
  logic [4:0]  out_active_count;
  logic        out_status;
  logic        out_last;

  // Predicted task table and the reports it still owes
  task_t        act_slot[TASK_SLOTS];
  int unsigned  act_used = 0;
  task_t        pend_slot[PENDING_SLOTS];
  int unsigned  pend_used = 0;
  fire_report_t due_reports[$];

  // Directed plan
  word_t        plan_words[$];
  bit           plan_typed[$];
  fire_report_t plan_expect[$];

  int unsigned  mismatches = 0;
  int unsigned  result_index = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_left = 0;
  bit           calm = 1'b0;
  bit           stall_req = 1'b0;
  logic [31:0]  real_clk_ms = '0;
  logic [31:0]  play_clk_ms = '0;

  deadline_task_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_owner_id        (in_owner_id),
    .in_use_real_clock  (in_use_real_clock),
    .in_delay_ms        (in_delay_ms),
    .in_task_tag        (in_task_tag),
    .in_real_now_ms     (in_real_now_ms),
    .in_playback_now_ms (in_playback_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_fired_valid    (out_fired_valid),
    .out_fired_owner    (out_fired_owner),
    .out_fired_tag      (out_fired_tag),
    .out_active_count   (out_active_count),
    .out_status         (out_status),
    .out_last           (out_last)
  );

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Run guard
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Single-word report: no fired task
  function automatic fire_report_t word_done(input logic [4:0] count, input logic status);
    return '{valid: 1'b0, owner: '0, tag: '0, count: count, status: status, last: 1'b1};
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Appends one expected report to the tail of the queue
  task automatic book_report(input fire_report_t r);
    due_reports = {due_reports, r};
  endtask

  // Predicts the table's reaction to one accepted word and queues the reports
  task automatic table_response(input word_t w);
    fire_report_t held;
    bit           have_held;
    logic [32:0]  sum;
    logic [31:0]  base;
    logic [31:0]  now;
    int unsigned  fired;
    int unsigned  kept;
    int unsigned  count;
    held = '0;
    have_held = 1'b0;
    fired = 0;
    kept = 0;
    case (w.op)
      OP_SCHED: begin
        base = w.real_sel ? w.real_now : w.play_now;
        sum = {1'b0, base} + {1'b0, w.delay};
        if (pend_used >= PENDING_SLOTS || act_used + pend_used >= TASK_SLOTS) begin
          book_report(word_done(5'd0, 1'b1));
        end else begin
          pend_slot[pend_used] = '{owner: w.owner,
                                   deadline: sum[32] ? DEADLINE_MAX : sum[31:0],
                                   tag: w.tag, real_clk: w.real_sel};
          pend_used++;
          book_report(word_done(5'd0, 1'b0));
        end
      end
      OP_TICK: begin
        count = act_used;
        // merge pending in order, then fire in table order
        for (int i = 0; i < pend_used; i++) begin
          if (act_used < TASK_SLOTS) begin
            act_slot[act_used] = pend_slot[i];
            act_used++;
          end
        end
        pend_used = 0;
        for (int i = 0; i < act_used; i++) begin
          now = act_slot[i].real_clk ? w.real_now : w.play_now;
          if (fired < RESULT_LIMIT && now > act_slot[i].deadline) begin
            if (have_held) book_report(held);
            held = '{valid: 1'b1, owner: act_slot[i].owner, tag: act_slot[i].tag,
                     count: (count > COUNT_SAT) ? COUNT_SAT : 5'(count),
                     status: 1'b0, last: 1'b0};
            have_held = 1'b1;
            fired++;
          end else begin
            act_slot[kept] = act_slot[i];
            kept++;
          end
        end
        act_used = kept;
        if (have_held) begin
          held.last = 1'b1;
          book_report(held);
        end else begin
          book_report(word_done((count > COUNT_SAT) ? COUNT_SAT : 5'(count), 1'b0));
        end
      end
      OP_REMOVE: begin
        // only active tasks go; pending ones survive
        for (int i = 0; i < act_used; i++) begin
          if (act_slot[i].owner != w.owner) begin
            act_slot[kept] = act_slot[i];
            kept++;
          end
        end
        act_used = kept;
        book_report(word_done(5'd0, 1'b0));
      end
      default: begin
        book_report(word_done(5'd0, 1'b0));
      end
    endcase
  endtask

  task automatic plan(input op_t op, input logic [31:0] owner, input logic real_sel,
                      input logic [31:0] delay, input logic [31:0] tag,
                      input logic [31:0] real_now, input logic [31:0] play_now,
                      input bit typed, input fire_report_t want);
    word_t w;
    w = '{op: op, owner: owner, real_sel: real_sel, delay: delay, tag: tag,
          real_now: real_now, play_now: play_now};
    plan_words = {plan_words, w};
    plan_typed = {plan_typed, typed};
    plan_expect = {plan_expect, want};
  endtask

  // Offers one word, waits for the handshake, then books the expected reports
  task automatic offer_word(input word_t w, input bit typed, input fire_report_t want);
    int unsigned booked;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_opcode = w.op;
    in_owner_id = w.owner;
    in_use_real_clock = w.real_sel;
    in_delay_ms = w.delay;
    in_task_tag = w.tag;
    in_real_now_ms = w.real_now;
    in_playback_now_ms = w.play_now;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    booked = due_reports.size();
    table_response(w);
    // typed rows: state follows the predictor, the check uses the literal
    if (typed) begin
      while (due_reports.size() > booked) void'(due_reports.pop_back());
      book_report(want);
    end
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    fire_report_t got;
    fire_report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{valid: out_fired_valid, owner: out_fired_owner, tag: out_fired_tag,
              count: out_active_count, status: out_status, last: out_last};
      if (due_reports.size() == 0) begin
        log_mismatch($sformatf("word %0d unexpected: fired %b owner %h tag %h",
                               result_index, got.valid, got.owner, got.tag));
      end else begin
        want = due_reports.pop_front();
        if (got.valid !== want.valid)
          log_mismatch($sformatf("word %0d fired_valid %b want %b",
                                 result_index, got.valid, want.valid));
        if (got.owner !== want.owner)
          log_mismatch($sformatf("word %0d fired_owner %h want %h",
                                 result_index, got.owner, want.owner));
        if (got.tag !== want.tag)
          log_mismatch($sformatf("word %0d fired_tag %h want %h",
                                 result_index, got.tag, want.tag));
        if (got.count !== want.count)
          log_mismatch($sformatf("word %0d active_count %0d want %0d",
                                 result_index, got.count, want.count));
        if (got.status !== want.status)
          log_mismatch($sformatf("word %0d status %b want %b",
                                 result_index, got.status, want.status));
        if (got.last !== want.last)
          log_mismatch($sformatf("word %0d last %b want %b",
                                 result_index, got.last, want.last));
      end
      result_index++;
    end
  end

  // Stimulus
  initial begin
    word_t       w;
    int unsigned sched_pct;
    int unsigned roll;
    int unsigned pick;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, unused opcode, remove with nothing active
    plan(OP_TICK, '0, 1'b0, '0, '0, '0, '0, 1'b1, word_done(5'd0, 1'b0));
    plan(OP_NONE, '1, 1'b1, '1, '1, '1, '1, 1'b1, word_done(5'd0, 1'b0));
    plan(OP_REMOVE, '0, 1'b0, '0, '0, '0, '0, 1'b1, word_done(5'd0, 1'b0));
    // saturated deadline on the real clock, zero deadline on playback
    plan(OP_SCHED, '1, 1'b1, '1, '1, '1, '0, 1'b1, word_done(5'd0, 1'b0));
    plan(OP_SCHED, '0, 1'b0, '0, '0, '1, '0, 1'b1, word_done(5'd0, 1'b0));
    for (int i = 1; i <= 6; i++)
      plan(OP_SCHED, (i % 3 == 0) ? 32'd7 : 32'd40 + i, i[0], 32'd100 * i + 1,
           32'hA000 + i, 32'd50 * i, 32'd20 * i, 1'b0, '0);
    // pending list full
    plan(OP_SCHED, 32'd5, 1'b0, 32'd1, 32'hDEAD, '0, '0, 1'b1, word_done(5'd0, 1'b1));
    // remove never touches pending tasks
    plan(OP_REMOVE, 32'd7, 1'b0, '0, '0, '0, '0, 1'b0, '0);
    plan(OP_TICK, '0, 1'b0, '0, '0, '0, '0, 1'b0, '0);
    for (int i = 1; i <= 8; i++)
      plan(OP_SCHED, (i % 2 == 0) ? 32'd7 : 32'd60 + i, i[1], 32'd300 * i,
           32'hB000 + i, 32'd10 * i, 32'd30 * i, 1'b0, '0);
    // active plus pending at capacity
    plan(OP_SCHED, 32'd5, 1'b1, 32'd1, 32'hBEEF, '0, '0, 1'b1, word_done(5'd0, 1'b1));
    plan(OP_REMOVE, 32'd7, 1'b0, '0, '0, '0, '0, 1'b0, '0);
    // everything due except the saturated deadline
    plan(OP_TICK, '0, 1'b0, '0, '0, '1, '1, 1'b0, '0);
    plan(OP_REMOVE, '1, 1'b0, '0, '0, '0, '0, 1'b0, '0);

    for (int i = 0; i < plan_words.size(); i++)
      offer_word(plan_words[i], plan_typed[i], plan_expect[i]);

    // Random traffic: running clocks, small owner set, schedule-heavy bursts
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = (k >= CALM_FROM && k < CALM_TO);
      if (k == STALL_AT) stall_req = 1'b1;
      sched_pct = ((k / 40) % 3 == 2) ? 75 : 48;

      if ($urandom_range(0, 99) < 8) real_clk_ms = $urandom;
      else real_clk_ms = real_clk_ms + $urandom_range(0, 250);
      pick = $urandom_range(0, 99);
      if (pick < 8) play_clk_ms = $urandom;
      else if (pick < 12) play_clk_ms = play_clk_ms - $urandom_range(0, 5000);
      else play_clk_ms = play_clk_ms + $urandom_range(0, 250);

      roll = $urandom_range(0, 99);
      if (roll < sched_pct) begin
        w.op = OP_SCHED;
      end else begin
        pick = $urandom_range(0, 99);
        w.op = (pick < 60) ? OP_TICK : (pick < 92) ? OP_REMOVE : OP_NONE;
      end
      w.owner = ($urandom_range(0, 99) < 12) ? $urandom : $urandom_range(0, 5);
      w.real_sel = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 8) w.delay = $urandom;
      else if (pick < 12) w.delay = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      else w.delay = $urandom_range(0, 1500);
      w.tag = $urandom;
      w.real_now = real_clk_ms;
      w.play_now = play_clk_ms;
      offer_word(w, 1'b0, '0);
    end
    calm = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    // Drain, then allow for a late stray word
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
